[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Each use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// cbd_pkg
// Types and constants shared by the chord detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int SOURCE_W          = 64;
  localparam int BUTTON_W          = 2;

  // Button patterns of interest.
  localparam logic [BUTTON_W-1:0] BUTTONS_NONE = 2'b00;
  localparam logic [BUTTON_W-1:0] CHORD_BOTH   = 2'b11;

  // One item as it leaves the input register, with its advance strobe.
  typedef struct packed {
    logic                fire;
    logic                has_sample;
    logic [SOURCE_W-1:0] source_id;
    logic [BUTTON_W-1:0] button_bits;
    logic                last_of_frame;
  } step_t;

  // Outcome of the table search for the current item.
  typedef struct packed {
    logic hit;
    logic hit_armed;
    logic full;
  } lookup_t;

endpackage

`default_nettype wire

[rtl/cbd_in_if.sv]
// ----------------------------------------------------------------------------
// cbd_in_if
// Sample channel: valid/ready handshake carrying one controller sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbd_in_if;
  logic        valid;
  logic        ready;
  logic        has_sample;
  logic [63:0] source_id;
  logic [1:0]  button_bits;
  logic        last_of_frame;

  modport source (output valid, has_sample, source_id, button_bits, last_of_frame,
                  input ready);
  modport sink   (input valid, has_sample, source_id, button_bits, last_of_frame,
                  output ready);
endinterface

`default_nettype wire

[rtl/cbd_out_if.sv]
// ----------------------------------------------------------------------------
// cbd_out_if
// Result channel: valid/ready handshake carrying one per-frame result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbd_out_if;
  logic valid;
  logic ready;
  logic open_triggered;
  logic chord_consumed;
  logic source_overflow;

  modport source (output valid, open_triggered, chord_consumed, source_overflow,
                  input ready);
  modport sink   (input valid, open_triggered, chord_consumed, source_overflow,
                  output ready);
endinterface

`default_nettype wire

[rtl/two_button_chord_detector.sv]
// Result path: the last item of a frame passes the input register, then the
//   result register, before its result leaves on the output channel.
// Throughput: one sample transaction per cycle, unless a last-of-frame item waits
//   for the result register; the table search is a parallel key compare.
// Reset (rst, synchronous, active high) empties the table and clears all
//   frame flags, the consumed flag and both pipeline valids.
// ----------------------------------------------------------------------------
// two_button_chord_detector
// Detects a two-button chord on an armed controller source, one result per
// poll frame, with a per-source table that drops sources absent from a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_chord_detector #(
  parameter int TABLE_ENTRIES = cbd_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cbd_in_if.sink    samples,
  cbd_out_if.source results
);
  import cbd_pkg::*;

  // Input register. Each accepted transaction is held here until it advances;
  // meanwhile the table search and all flag updates are worked out, and they
  // are written back at the edge on which it advances.
  logic                in_vld;
  logic                in_has;
  logic [SOURCE_W-1:0] in_id;
  logic [BUTTON_W-1:0] in_btn;
  logic                in_last;

  step_t   step;
  lookup_t lookup;
  logic    out_free;
  logic    advance;

  // An item without last_of_frame gives no result and always advances. The
  // last item of a frame advances only when the result register can take it,
  // either because it is empty or because its transaction completes now.
  assign advance = in_vld && (!in_last || out_free);

  // The input register takes a new transaction whenever it is empty or its
  // current item advances in this cycle, so back-to-back items flow freely.
  assign samples.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (samples.ready) begin
      in_vld <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      in_has  <= samples.has_sample;
      in_id   <= samples.source_id;
      in_btn  <= samples.button_bits;
      in_last <= samples.last_of_frame;
    end
  end

  assign step.fire          = advance;
  assign step.has_sample    = in_has;
  assign step.source_id     = in_id;
  assign step.button_bits   = in_btn;
  assign step.last_of_frame = in_last;

  // Source table: keys, valid, armed and seen flags per entry.
  cbd_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .lookup (lookup)
  );

  // Frame-level flags and the result register feeding the output channel.
  cbd_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .lookup   (lookup),
    .out_free (out_free),
    .results  (results)
  );

endmodule

`default_nettype wire

[rtl/cbd_table.sv]
// ----------------------------------------------------------------------------
// cbd_table
// Source table: per-entry key lanes with parallel compare and flag vectors.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbd_table #(
  parameter int TABLE_ENTRIES = cbd_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cbd_pkg::step_t  step,
  output cbd_pkg::lookup_t     lookup
);
  import cbd_pkg::*;

  logic [SOURCE_W-1:0]      keys [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid, valid_next;
  logic [TABLE_ENTRIES-1:0] armed, armed_next;
  logic [TABLE_ENTRIES-1:0] seen, seen_next;

  logic [TABLE_ENTRIES-1:0] match, hit_oh, free_oh, set_mask;
  logic [TABLE_ENTRIES-1:0] valid_mid, armed_mid, seen_mid;
  logic                     upd;

  // Parallel key compare, only over valid entries.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == step.source_id);
    end
  end

  // Lowest matching entry and lowest free entry.
  assign hit_oh  = match & (-match);
  assign free_oh = (~valid) & (-(~valid));

  assign lookup.hit       = |match;
  assign lookup.hit_armed = |(hit_oh & armed);
  assign lookup.full      = &valid;

  assign upd = step.fire && step.has_sample;

  always_comb begin
    set_mask = '0;
    if (upd) begin
      set_mask = lookup.hit ? hit_oh : free_oh;
    end
    valid_mid = valid | set_mask;
    seen_mid  = seen | set_mask;
    // A new entry is unarmed, so OR-ing covers both hit and new-slot cases.
    armed_mid = armed | ((step.button_bits == BUTTONS_NONE) ? set_mask : '0);

    valid_next = valid_mid;
    armed_next = armed_mid;
    seen_next  = seen_mid;
    if (step.fire && step.last_of_frame) begin
      valid_next = valid_mid & seen_mid;
      armed_next = armed_mid & seen_mid;
      seen_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      armed <= '0;
      seen  <= '0;
    end else begin
      valid <= valid_next;
      armed <= armed_next;
      seen  <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (upd && !lookup.hit && free_oh[i]) begin
        keys[i] <= step.source_id;
      end
    end
  end

  `ASSERT_ALWAYS(a_hit_onehot, $onehot0(hit_oh))
  `ASSERT_ALWAYS(a_armed_valid, (armed & ~valid) == '0)
  `ASSERT_ALWAYS(a_seen_valid, (seen & ~valid) == '0)
  `ASSERT_NEXT(a_frame_clears_seen, step.fire && step.last_of_frame, seen == '0)

endmodule

`default_nettype wire

[rtl/cbd_frame.sv]
// ----------------------------------------------------------------------------
// cbd_frame
// Frame flags, consumed flag and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbd_frame (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cbd_pkg::step_t   step,
  input  wire cbd_pkg::lookup_t lookup,
  output logic                  out_free,
  cbd_out_if.source             results
);
  import cbd_pkg::*;

  logic chord_used, chord_used_next;
  logic any_button, any_button_next;
  logic trigger, trigger_next;
  logic overflow, overflow_next;
  logic out_valid, out_valid_next;
  logic trig_now, ovf_now, any_f, trig_f, ovf_f, used_f, load;

  assign out_free = !out_valid || results.ready;
  assign load     = step.fire && step.last_of_frame;

  always_comb begin
    trig_now = step.has_sample && lookup.hit && lookup.hit_armed &&
               (step.button_bits == CHORD_BOTH) && !chord_used;
    ovf_now  = step.has_sample && !lookup.hit && lookup.full;
    any_f    = any_button || (step.has_sample && (step.button_bits != BUTTONS_NONE));
    trig_f   = trigger || trig_now;
    ovf_f    = overflow || ovf_now;
    used_f   = trig_f || (any_f && chord_used);

    any_button_next = any_button;
    trigger_next    = trigger;
    overflow_next   = overflow;
    chord_used_next = chord_used;
    if (step.fire) begin
      if (step.last_of_frame) begin
        any_button_next = 1'b0;
        trigger_next    = 1'b0;
        overflow_next   = 1'b0;
        chord_used_next = used_f;
      end else begin
        any_button_next = any_f;
        trigger_next    = trig_f;
        overflow_next   = ovf_f;
      end
    end

    out_valid_next = out_valid && !results.ready;
    if (load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chord_used <= 1'b0;
      any_button <= 1'b0;
      trigger    <= 1'b0;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      chord_used <= chord_used_next;
      any_button <= any_button_next;
      trigger    <= trigger_next;
      overflow   <= overflow_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.open_triggered  <= trig_f;
      results.chord_consumed  <= used_f;
      results.source_overflow <= ovf_f;
    end
  end

  assign results.valid = out_valid;

  `ASSERT_IMPLIES(a_trigger_unused, trigger, !chord_used)
  `ASSERT_IMPLIES(a_load_has_room, load, out_free)
  `ASSERT_IMPLIES(a_fired_consumed, out_valid && results.open_triggered,
                  results.chord_consumed)

endmodule

`default_nettype wire
